FILE: sv/mhpf_pkg.sv
// mhpf_pkg: shared types and constants of the mesh header parse and forward unit
// used by mhpf_parser, mhpf_out_buf and mesh_header_parse_and_forward_unit
`default_nettype none

package mhpf_pkg;

  localparam logic [3:0]  HOP_ESCAPE = 4'hF;
  localparam logic [31:0] BROADCAST  = 32'h0000_00FF;

  typedef enum logic [1:0] {
    VERDICT_DELIVER   = 2'd0,
    VERDICT_FORWARD   = 2'd1,
    VERDICT_DROP      = 2'd2,
    VERDICT_MALFORMED = 2'd3
  } verdict_e;

  typedef enum logic [4:0] {
    PH_FLAG = 5'b00001,
    PH_ID   = 5'b00010,
    PH_HOP  = 5'b00100,
    PH_SRC  = 5'b01000,
    PH_DST  = 5'b10000
  } phase_e;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] packet_id;
    logic [7:0]  hop_received;
    logic [7:0]  hop_forward;
    logic [3:0]  header_bytes;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/mesh_header_parse_and_forward_unit.sv
// mesh_header_parse_and_forward_unit: top level with config register and channels
// depends on mhpf_pkg, mhpf_parser and mhpf_out_buf
//
// Usage:
// - input channel (in_valid_i / in_ready_o) carries one frame byte per request,
//   with frame_end_i marking the last byte of the frame
// - result channel (out_valid_o / out_ready_i) carries one verdict per frame:
//   deliver, forward, drop on exhausted hop count, or malformed
// - the APB-style port holds node_address at byte address 0; pready is tied high
// - throughput is one byte per cycle; each byte is a single field update in the
//   parser registers, so there is no stall on the input side while the result
//   side keeps up
// - the result enters the registered result buffer as the byte that completes
//   the header (or the early frame_end byte) is accepted, behind older results
// - a two-entry result buffer lets bytes keep flowing while a result waits;
//   in_ready_o drops only while both entries are held by a stalled receiver
// - reset clears the parser to the flag byte, empties the buffer and sets
//   node_address to zero
// - write node_address only while no frame is in flight
`default_nettype none

module mesh_header_parse_and_forward_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       verdict_o,
  output logic [31:0]      source_address_o,
  output logic [31:0]      destination_address_o,
  output logic [15:0]      packet_id_o,
  output logic [7:0]       hop_received_o,
  output logic [7:0]       hop_forward_o,
  output logic [3:0]       header_bytes_o
);
  import mhpf_pkg::*;

  logic [31:0] node_address_q, node_address_d;
  logic        cfg_wr;
  logic        step;
  logic        res_valid;
  result_t     res;
  result_t     out_data;
  logic        buf_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? node_address_q : 32'd0;

  always_comb begin
    node_address_d = node_address_q;
    if (cfg_wr) begin
      node_address_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= '0;
    end else begin
      node_address_q <= node_address_d;
    end
  end

  assign in_ready_o = !buf_full;
  assign step       = in_valid_i && in_ready_o;

  mhpf_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_valid_i   (step),
    .frame_byte_i   (frame_byte_i),
    .frame_end_i    (frame_end_i),
    .node_address_i (node_address_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  mhpf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign verdict_o             = out_data.verdict;
  assign source_address_o      = out_data.source_address;
  assign destination_address_o = out_data.destination_address;
  assign packet_id_o           = out_data.packet_id;
  assign hop_received_o        = out_data.hop_received;
  assign hop_forward_o         = out_data.hop_forward;
  assign header_bytes_o        = out_data.header_bytes;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result buffer");

  a_fwd_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (verdict_o != VERDICT_FORWARD)) |-> (hop_forward_o == 8'd0))
    else $error("hop_forward set on a non-forward verdict");

  a_malformed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (verdict_o == VERDICT_MALFORMED)) |-> (header_bytes_o == 4'd0))
    else $error("malformed result carries a header length");

endmodule

`default_nettype wire

FILE: sv/mhpf_parser.sv
// mhpf_parser: byte-wise header field parser with per-frame verdict
// depends on mhpf_pkg (phase_e, verdict_e, result_t)
`default_nettype none

module mhpf_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_valid_i,
  input  wire logic [7:0]       frame_byte_i,
  input  wire logic             frame_end_i,
  input  wire logic [31:0]      node_address_i,
  output logic                  res_valid_o,
  output mhpf_pkg::result_t     res_o
);
  import mhpf_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  hop_q, hop_d;
  logic        done_q, done_d;
  logic        complete;
  logic        escaped;

  assign escaped = (flags_q[7:4] == HOP_ESCAPE);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    flags_d     = flags_q;
    src_d       = src_q;
    dst_d       = dst_q;
    id_d        = id_q;
    hop_d       = hop_q;
    done_d      = done_q;
    complete    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_valid_i) begin
      if (done_q) begin
        // payload bytes, wait for the end of the frame
        if (frame_end_i) begin
          phase_d = PH_FLAG;
          cnt_d   = 2'd0;
          done_d  = 1'b0;
        end
      end else begin
        case (phase_q)
          PH_ID: begin
            if (cnt_q[0]) begin
              id_d[15:8] = frame_byte_i;
            end else begin
              id_d[7:0] = frame_byte_i;
            end
            if (cnt_q == 2'd1) begin
              cnt_d   = 2'd0;
              phase_d = escaped ? PH_HOP : PH_SRC;
            end else begin
              cnt_d = cnt_q + 2'd1;
            end
          end
          PH_HOP: begin
            hop_d   = frame_byte_i;
            phase_d = PH_SRC;
          end
          PH_SRC: begin
            src_d = {src_q[23:0], frame_byte_i};
            if (cnt_q == flags_q[1:0]) begin
              cnt_d   = 2'd0;
              phase_d = PH_DST;
            end else begin
              cnt_d = cnt_q + 2'd1;
            end
          end
          PH_DST: begin
            dst_d = {dst_q[23:0], frame_byte_i};
            if (cnt_q == flags_q[3:2]) begin
              cnt_d    = 2'd0;
              complete = 1'b1;
            end else begin
              cnt_d = cnt_q + 2'd1;
            end
          end
          default: begin
            // flag byte, also taken for any unused phase code
            flags_d = frame_byte_i;
            hop_d   = {4'd0, frame_byte_i[7:4]};
            src_d   = '0;
            dst_d   = '0;
            id_d    = '0;
            cnt_d   = 2'd0;
            phase_d = PH_ID;
          end
        endcase

        if (complete) begin
          res_valid_o                = 1'b1;
          res_o.source_address       = src_d;
          res_o.destination_address  = dst_d;
          res_o.packet_id            = id_d;
          res_o.hop_received         = hop_q;
          res_o.header_bytes         = 4'd5 + {3'd0, escaped} + {2'd0, flags_q[1:0]}
                                       + {2'd0, flags_q[3:2]};
          if ((dst_d == node_address_i) || (dst_d == BROADCAST)) begin
            res_o.verdict = VERDICT_DELIVER;
          end else if (hop_q == 8'd0) begin
            res_o.verdict = VERDICT_DROP;
          end else begin
            res_o.verdict     = VERDICT_FORWARD;
            res_o.hop_forward = hop_q - 8'd1;
          end
          if (frame_end_i) begin
            phase_d = PH_FLAG;
            cnt_d   = 2'd0;
            done_d  = 1'b0;
          end else begin
            done_d = 1'b1;
          end
        end else if (frame_end_i) begin
          // frame cut short inside the header
          res_valid_o   = 1'b1;
          res_o.verdict = VERDICT_MALFORMED;
          phase_d       = PH_FLAG;
          cnt_d         = 2'd0;
          done_d        = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAG;
      cnt_q   <= 2'd0;
      flags_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      id_q    <= '0;
      hop_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      id_q    <= id_d;
      hop_q   <= hop_d;
      done_q  <= done_d;
    end
  end

  a_res_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> step_valid_i)
    else $error("parser result without an accepted byte");

  a_no_res_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_valid_i && done_q) |-> !res_valid_o)
    else $error("parser result during payload bytes");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_valid_i && frame_end_i) |=> (phase_q == PH_FLAG) && !done_q)
    else $error("parser did not restart after frame end");

endmodule

`default_nettype wire

FILE: sv/mhpf_out_buf.sv
// mhpf_out_buf: two-entry result buffer between parser and result channel
// depends on mhpf_pkg (result_t)
`default_nettype none

module mhpf_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mhpf_pkg::result_t push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output mhpf_pkg::result_t     out_data_o
);
  import mhpf_pkg::*;

  result_t    e0_q, e0_d;
  result_t    e1_q, e1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign out_data_o  = e0_q;

  always_comb begin
    e0_d  = e0_q;
    e1_d  = e1_q;
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          e0_d = push_data_i;
        end else begin
          e1_d = push_data_i;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        e0_d  = e1_q;
        cnt_d = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          e0_d = push_data_i;
        end else begin
          e0_d = e1_q;
          e1_d = push_data_i;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result pushed into full buffer");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("result buffer count wrong after pop");

endmodule

`default_nettype wire
